### hdl/bilinear_integer_upscale_unit_assert.svh
// assertion macros shared by the checker files of the upscaler
`ifndef BILINEAR_INTEGER_UPSCALE_UNIT_ASSERT_SVH
`define BILINEAR_INTEGER_UPSCALE_UNIT_ASSERT_SVH

// property checked only while out of reset
`define BIU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// property that must also hold while reset is applied
`define BIU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/biu_pkg.sv
// shared types, constants and helpers of the bilinear upscaler
package biu_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_FACTOR = 16;

	localparam int PIX_W   = 8;
	localparam int COORD_W = 12;
	localparam int SF_W    = 5;
	localparam int SW_W    = 9;
	localparam int SH_W    = 9;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 2;

	// effective factor, width and height counts
	localparam int FW = $clog2(MAX_FACTOR + 1);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	// source column and row indexes
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);

	// divider sizing: quotient never exceeds a source index or a pixel value
	localparam int QW0   = (XW > YW) ? XW : YW;
	localparam int QW    = (QW0 > PIX_W) ? QW0 : PIX_W;
	localparam int DIV_W = 2 * FW;
	localparam int DS_W  = DIV_W + QW;
	localparam int CNT_W = $clog2(QW + 1);
	localparam int SUM_W = PIX_W + DIV_W;

	localparam int LIM_W = (WW > HW) ? WW + FW : HW + FW;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVX,
		ST_DIVY,
		ST_WEIGHT,
		ST_READ,
		ST_DIVS,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [FW-1:0] factor;
		logic [WW-1:0] width;
		logic [HW-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DS_W-1:0]  dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QW-1:0]    quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [XW-1:0] x,
		input logic [YW-1:0] y);
		return ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
	endfunction

endpackage

### hdl/bilinear_integer_upscale_unit.sv
// Gray-scale bilinear upscaler with an integer factor. A load item writes one
// source pixel into the on-chip pixel store (loads outside the configured
// source size are dropped and give no result). A query item returns one pixel
// of the enlarged image: the four source neighbors are read one per cycle
// from the single-port store, blended with integer weights and divided by
// factor squared with truncation; neighbors past the right or bottom edge
// count as zero. A query makes three passes through the shared one-bit-per-cycle
// divider (column, row, final blend) around the four store reads; a query
// outside the enlarged image is answered with the flag set. A query must only
// touch source pixels that were loaded; the store is not cleared after reset.
// A finished result waits in an output register, so the next item is taken
// while it is still stalled. The user must write configuration only while the
// block is idle; the block itself does not enforce this.
module bilinear_integer_upscale_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [biu_pkg::COORD_W-1:0]    coord_x,
	input  logic [biu_pkg::COORD_W-1:0]    coord_y,
	input  logic [biu_pkg::PIX_W-1:0]      pixel_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [biu_pkg::PIX_W-1:0]      pixel_out,
	output logic                           out_of_range,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [biu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [biu_pkg::CFG_DATA_W-1:0] cfg_data
);
	import biu_pkg::*;

	cfg_t     cfg;
	div_req_t div_req;
	div_rsp_t div_rsp;

	state_t state_q, state_d;

	logic [COORD_W-1:0] cx_q, cy_q;
	logic [XW-1:0]      ox_q;
	logic [YW-1:0]      oy_q;
	logic [FW-1:0]      dx_q, dy_q;
	logic [DIV_W-1:0]   wgt_q [4];
	logic               edge_x_q, edge_y_q;
	logic [2:0]         rd_cnt_q;
	logic               rd_vld_s1;
	logic [1:0]         rd_idx_s1;
	logic               rd_zero_s1;
	logic [SUM_W-1:0]   acc_q;
	logic [PIX_W-1:0]   res_pix_q;
	logic               res_oor_q;
	logic               out_valid_q;
	logic [PIX_W-1:0]   out_pixel_q;
	logic               out_oor_q;

	logic              in_accept;
	logic              load_hit;
	logic              oor;
	logic [LIM_W-1:0]  lim_x, lim_y;
	logic [1:0]        nb;
	logic [XW-1:0]     nx;
	logic [YW-1:0]     ny;
	logic              nb_zero;
	logic              rd_issue;
	logic              out_load;
	logic [ADDR_W-1:0] ram_addr;
	logic [PIX_W-1:0]  ram_rdata;
	logic [PIX_W-1:0]  blend_pix;
	logic [FW-1:0]     fx0, fy0;

	biu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	biu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	biu_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (load_hit),
		.addr  (ram_addr),
		.wdata (pixel_in),
		.rdata (ram_rdata)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign load_hit  = in_accept && (cmd == CMD_LOAD)
		&& (32'(coord_x) < 32'(cfg.width)) && (32'(coord_y) < 32'(cfg.height));

	assign lim_x = LIM_W'(cfg.width) * LIM_W'(cfg.factor);
	assign lim_y = LIM_W'(cfg.height) * LIM_W'(cfg.factor);
	assign oor   = (32'(cx_q) >= 32'(lim_x)) || (32'(cy_q) >= 32'(lim_y));

	// neighbor order: origin, right, below, diagonal
	assign nb       = rd_cnt_q[1:0];
	assign nx       = ox_q + XW'(nb[0]);
	assign ny       = oy_q + YW'(nb[1]);
	assign nb_zero  = (nb[0] && edge_x_q) || (nb[1] && edge_y_q);
	assign rd_issue = (state_q == ST_READ) && !rd_cnt_q[2];

	assign ram_addr = load_hit ? pix_addr(coord_x[XW-1:0], coord_y[YW-1:0])
		: pix_addr(nx, ny);

	assign blend_pix = rd_zero_s1 ? '0 : ram_rdata;
	assign fx0       = cfg.factor - dx_q;
	assign fy0       = cfg.factor - dy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (state_q == ST_WEIGHT) begin
				rd_cnt_q <= '0;
			end else if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		out_load         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && (cmd == CMD_QUERY)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (oor) begin
					state_d = ST_RESULT;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = DS_W'(cx_q);
					div_req.divisor  = DIV_W'(cfg.factor);
					state_d          = ST_DIVX;
				end
			end
			ST_DIVX: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = DS_W'(cy_q);
					div_req.divisor  = DIV_W'(cfg.factor);
					state_d          = ST_DIVY;
				end
			end
			ST_DIVY: begin
				if (div_rsp.done) begin
					state_d = ST_WEIGHT;
				end
			end
			ST_WEIGHT: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				// last product lands in the accumulator in the cycle after its read
				if (rd_cnt_q == 3'd5) begin
					div_req.start    = 1'b1;
					div_req.dividend = DS_W'(acc_q);
					div_req.divisor  = DIV_W'(cfg.factor) * DIV_W'(cfg.factor);
					state_d          = ST_DIVS;
				end
			end
			ST_DIVS: begin
				if (div_rsp.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept && (cmd == CMD_QUERY)) begin
			cx_q <= coord_x;
			cy_q <= coord_y;
		end
		if (state_q == ST_CHECK) begin
			res_oor_q <= oor;
			res_pix_q <= '0;
		end
		if ((state_q == ST_DIVX) && div_rsp.done) begin
			ox_q <= div_rsp.quot[XW-1:0];
			dx_q <= div_rsp.rem[FW-1:0];
		end
		if ((state_q == ST_DIVY) && div_rsp.done) begin
			oy_q <= div_rsp.quot[YW-1:0];
			dy_q <= div_rsp.rem[FW-1:0];
		end
		if (state_q == ST_WEIGHT) begin
			wgt_q[0] <= DIV_W'(fx0) * DIV_W'(fy0);
			wgt_q[1] <= DIV_W'(dx_q) * DIV_W'(fy0);
			wgt_q[2] <= DIV_W'(fx0) * DIV_W'(dy_q);
			wgt_q[3] <= DIV_W'(dx_q) * DIV_W'(dy_q);
			edge_x_q <= (32'(ox_q) + 1 == 32'(cfg.width));
			edge_y_q <= (32'(oy_q) + 1 == 32'(cfg.height));
			acc_q    <= '0;
		end else if (rd_vld_s1) begin
			acc_q <= acc_q + SUM_W'(blend_pix) * SUM_W'(wgt_q[rd_idx_s1]);
		end
		rd_idx_s1  <= nb;
		rd_zero_s1 <= nb_zero;
		if ((state_q == ST_DIVS) && div_rsp.done) begin
			res_pix_q <= div_rsp.quot[PIX_W-1:0];
			res_oor_q <= 1'b0;
		end
		if (out_load) begin
			out_pixel_q <= res_pix_q;
			out_oor_q   <= res_oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_out    = out_pixel_q;
	assign out_of_range = out_oor_q;

endmodule

### hdl/biu_ram.sv
// generic single-port ram with registered read
module biu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### hdl/biu_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module biu_div (
	input  logic              clk,
	input  logic              arst_n,
	input  biu_pkg::div_req_t req,
	output biu_pkg::div_rsp_t rsp
);
	import biu_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DS_W-1:0]  rem_q;
	logic [DS_W-1:0]  ds_q;
	logic [QW-1:0]    quo_q;
	logic             fit;

	assign fit = (rem_q >= ds_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// divisor starts aligned to the top quotient bit and walks right
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			ds_q  <= DS_W'(req.divisor) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fit) begin
				rem_q <= rem_q - ds_q;
			end
			quo_q <= {quo_q[QW-2:0], fit};
			ds_q  <= ds_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q[DIV_W-1:0];

endmodule

### hdl/biu_cfg.sv
// configuration registers and clamping to the supported ranges
module biu_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [biu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [biu_pkg::CFG_DATA_W-1:0] cfg_data,
	output biu_pkg::cfg_t                  cfg
);
	import biu_pkg::*;

	logic [SF_W-1:0] sf_q;
	logic [SW_W-1:0] sw_q;
	logic [SH_W-1:0] sh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q <= SF_W'(1);
			sw_q <= SW_W'(256);
			sh_q <= SH_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SCALE: begin
					sf_q <= cfg_data[SF_W-1:0];
				end
				REG_WIDTH: begin
					sw_q <= cfg_data[SW_W-1:0];
				end
				REG_HEIGHT: begin
					sh_q <= cfg_data[SH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (sf_q == '0) begin
			cfg.factor = FW'(1);
		end else if (32'(sf_q) > MAX_FACTOR) begin
			cfg.factor = FW'(MAX_FACTOR);
		end else begin
			cfg.factor = FW'(sf_q);
		end

		if (sw_q == '0) begin
			cfg.width = WW'(1);
		end else if (32'(sw_q) > MAX_WIDTH) begin
			cfg.width = WW'(MAX_WIDTH);
		end else begin
			cfg.width = WW'(sw_q);
		end

		if (sh_q == '0) begin
			cfg.height = HW'(1);
		end else if (32'(sh_q) > MAX_HEIGHT) begin
			cfg.height = HW'(MAX_HEIGHT);
		end else begin
			cfg.height = HW'(sh_q);
		end
	end

endmodule

### hdl/biu_checker.sv
// port-level checks of the upscaler, bound to the top level
`include "bilinear_integer_upscale_unit_assert.svh"

module biu_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        cmd,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [biu_pkg::PIX_W-1:0]   pixel_out,
	input logic                        out_of_range
);
	import biu_pkg::*;

	// reset is asynchronous; check that no result is shown in the cycle after reset is seen
	`BIU_ASSERT_ALWAYS(a_reset_no_out, !arst_n |=> !out_valid, "result shown during reset")

	`BIU_ASSERT(a_out_hold,
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(out_of_range),
		"stalled result changed")

	`BIU_ASSERT(a_flag_zero,
		out_valid && out_of_range |-> pixel_out == '0,
		"flagged result carries a pixel value")

	`BIU_ASSERT(a_query_busy,
		in_valid && !in_stall && cmd == CMD_QUERY |=> in_stall,
		"new item taken while a query is in progress")

	`BIU_ASSERT(a_load_silent,
		in_valid && !in_stall && cmd == CMD_LOAD && !out_valid |=> !out_valid,
		"load item produced a result")

endmodule

bind bilinear_integer_upscale_unit biu_checker u_biu_checker (.*);

### test/bilinear_integer_upscale_unit_checker.sv
`timescale 1ns / 100ps
// result checker for the bilinear upscaler: mirrors store and registers, predicts each query
module bilinear_integer_upscale_unit_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           cmd,
	input  logic [biu_pkg::COORD_W-1:0]    coord_x,
	input  logic [biu_pkg::COORD_W-1:0]    coord_y,
	input  logic [biu_pkg::PIX_W-1:0]      pixel_in,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [biu_pkg::PIX_W-1:0]      pixel_out,
	input  logic                           out_of_range,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [biu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [biu_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             waiting,
	output int                             mismatches
);
	import biu_pkg::*;

	localparam int REPORT_LINES = 40;

	typedef struct {
		logic [PIX_W-1:0]   pixel;
		logic               flag;
		logic [COORD_W-1:0] qx;
		logic [COORD_W-1:0] qy;
	} upscaled_px_t;

	logic [PIX_W-1:0] src_mem [MAX_WIDTH*MAX_HEIGHT];
	logic [SF_W-1:0]  factor_reg = 1;
	logic [SW_W-1:0]  width_reg  = 256;
	logic [SH_W-1:0]  height_reg = 256;
	upscaled_px_t     upscaled_q [$];
	upscaled_px_t     due;

	// zero acts as one, anything past the maximum as the maximum
	function automatic int unsigned clamp_cfg(input int unsigned raw, input int unsigned hi);
		if (raw == 0)
			return 1;
		return (raw > hi) ? hi : raw;
	endfunction

	function automatic bit in_source(input int unsigned x, input int unsigned y);
		return x < clamp_cfg(width_reg, MAX_WIDTH) && y < clamp_cfg(height_reg, MAX_HEIGHT);
	endfunction

	// neighbors past the right or bottom edge read as zero
	function automatic int unsigned src_px(input int unsigned x, input int unsigned y);
		if (!in_source(x, y))
			return 0;
		return src_mem[y*MAX_WIDTH + x];
	endfunction

	function automatic upscaled_px_t blend_pixel(input logic [COORD_W-1:0] qx,
		input logic [COORD_W-1:0] qy);
		int unsigned f, w, h, cx, cy, dx, dy, acc;
		upscaled_px_t r;
		f = clamp_cfg(factor_reg, MAX_FACTOR);
		w = clamp_cfg(width_reg, MAX_WIDTH);
		h = clamp_cfg(height_reg, MAX_HEIGHT);
		r.qx = qx;
		r.qy = qy;
		r.pixel = '0;
		r.flag = 1'b0;
		if (qx >= w*f || qy >= h*f) begin
			r.flag = 1'b1;
			return r;
		end
		cx = qx / f;
		cy = qy / f;
		dx = qx % f;
		dy = qy % f;
		acc = src_px(cx, cy) * (f - dx) * (f - dy)
			+ src_px(cx + 1, cy) * dx * (f - dy)
			+ src_px(cx, cy + 1) * (f - dx) * dy
			+ src_px(cx + 1, cy + 1) * dx * dy;
		r.pixel = PIX_W'(acc / (f*f));
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < REPORT_LINES)
			$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_reg = 1;
			width_reg = 256;
			height_reg = 256;
			upscaled_q.delete();
			mismatches = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (upscaled_q.size() == 0) begin
					report_mismatch($sformatf("result pixel %0d flag %0b with no query waiting",
						pixel_out, out_of_range));
				end else begin
					due = upscaled_q.pop_front();
					if (out_of_range !== due.flag)
						report_mismatch($sformatf("query (%0d,%0d) out_of_range %0b, want %0b",
							due.qx, due.qy, out_of_range, due.flag));
					if (pixel_out !== due.pixel)
						report_mismatch($sformatf("query (%0d,%0d) pixel_out %0d, want %0d",
							due.qx, due.qy, pixel_out, due.pixel));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCALE:  factor_reg = cfg_data[SF_W-1:0];
					REG_WIDTH:  width_reg = cfg_data[SW_W-1:0];
					REG_HEIGHT: height_reg = cfg_data[SH_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_QUERY)
					upscaled_q.push_back(blend_pixel(coord_x, coord_y));
				else if (in_source(coord_x, coord_y))
					src_mem[coord_y*MAX_WIDTH + coord_x] = pixel_in;
			end
		end
		waiting <= upscaled_q.size();
	end

endmodule

### test/bilinear_integer_upscale_unit_tb.sv
`timescale 1ns / 100ps
// testbench top for the bilinear upscaler: clock, reset, load and query items, verdict
module bilinear_integer_upscale_unit_tb;
	import biu_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_ITEMS  = 115;
	localparam int WINDOW       = 8;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  cmd;
	logic [COORD_W-1:0]    coord_x;
	logic [COORD_W-1:0]    coord_y;
	logic [PIX_W-1:0]      pixel_in;
	logic                  out_valid;
	logic                  out_stall;
	logic [PIX_W-1:0]      pixel_out;
	logic                  out_of_range;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    waiting;
	int                    mismatches;

	// source pixels known to hold a value; queries only touch these
	bit          loaded [MAX_WIDTH*MAX_HEIGHT];
	int unsigned eff_f, eff_w, eff_h;
	bit          quiet;
	int unsigned cycles = 0;
	int unsigned n_loads = 0, n_dropped = 0, n_queries = 0, n_flagged = 0, n_settings = 0;

	// factor, width, height as written; some raw values lie outside the legal range
	int unsigned plan [13][3] = '{
		'{2, 5, 4}, '{16, 1, 1}, '{1, 16, 16}, '{3, 7, 3}, '{16, 256, 2},
		'{5, 2, 256}, '{7, 13, 11}, '{1, 256, 256}, '{16, 256, 256}, '{9, 1, 9},
		'{12, 4, 1}, '{2, 20, 12}, '{20, 0, 400}
	};

	bilinear_integer_upscale_unit i_dut (.*);

	bilinear_integer_upscale_unit_checker i_check (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("bilinear_integer_upscale_unit_tb failed");
			$finish;
		end
	end

	function automatic int unsigned draw_gap();
		return quiet ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic int unsigned clamp_cfg(input int unsigned raw, input int unsigned hi);
		if (raw == 0)
			return 1;
		return (raw > hi) ? hi : raw;
	endfunction

	// every in-image neighbor that the blend reads has been loaded
	function automatic bit neighbors_loaded(input int unsigned x, input int unsigned y);
		int unsigned ox, oy, i, j;
		if (x >= eff_w*eff_f || y >= eff_h*eff_f)
			return 1'b1;
		ox = x / eff_f;
		oy = y / eff_f;
		for (j = 0; j < 2; j++)
			for (i = 0; i < 2; i++)
				if (ox + i < eff_w && oy + j < eff_h && !loaded[(oy + j)*MAX_WIDTH + ox + i])
					return 1'b0;
		return 1'b1;
	endfunction

	// receiver side: hold stall for a random count after each taken result
	initial begin
		int unsigned hold;
		out_stall = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				hold = draw_gap();
				out_stall <= (hold != 0);
			end else if (hold > 1) begin
				hold--;
			end else begin
				hold = 0;
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic op, input int unsigned x, input int unsigned y,
		input logic [PIX_W-1:0] p);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		coord_x <= COORD_W'(x);
		coord_y <= COORD_W'(y);
		pixel_in <= p;
		do @(posedge clk); while (in_stall);
		if (op == CMD_LOAD) begin
			n_loads++;
			if (x < eff_w && y < eff_h)
				loaded[y*MAX_WIDTH + x] = 1'b1;
			else
				n_dropped++;
		end else begin
			n_queries++;
			if (x >= eff_w*eff_f || y >= eff_h*eff_f)
				n_flagged++;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned f, input int unsigned w, input int unsigned h);
		write_reg(REG_SCALE, f);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		eff_f = clamp_cfg(f, MAX_FACTOR);
		eff_w = clamp_cfg(w, MAX_WIDTH);
		eff_h = clamp_cfg(h, MAX_HEIGHT);
		n_settings++;
	endtask

	// drain all results, then give a trailing load time to finish
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned x, y, x0, y0, win_w, win_h, pick, tries;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		coord_x = '0;
		coord_y = '0;
		pixel_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SCALE;
		cfg_data = '0;
		quiet = 1'b0;
		eff_f = 1;
		eff_w = MAX_WIDTH;
		eff_h = MAX_HEIGHT;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: queries past the enlarged image, dropped loads, far corner
		send_item(CMD_QUERY, 256, 0, 8'h00);
		send_item(CMD_QUERY, 0, 256, 8'hff);
		send_item(CMD_QUERY, 4095, 4095, 8'h00);
		send_item(CMD_LOAD, 4095, 0, 8'haa);
		send_item(CMD_LOAD, 0, 4095, 8'h55);
		send_item(CMD_LOAD, 255, 255, 8'h5a);
		send_item(CMD_QUERY, 255, 255, 8'h00);
		settle();

		// tiny 3x2 image at factor 4, full-scale pixels to stress the blend sum
		configure(4, 3, 2);
		send_item(CMD_LOAD, 0, 0, 8'hff);
		send_item(CMD_LOAD, 1, 0, 8'hff);
		send_item(CMD_LOAD, 2, 0, 8'h00);
		send_item(CMD_LOAD, 0, 1, 8'hff);
		send_item(CMD_LOAD, 1, 1, 8'hff);
		send_item(CMD_LOAD, 2, 1, 8'h11);
		send_item(CMD_LOAD, 3, 0, 8'h09);
		send_item(CMD_QUERY, 0, 0, 8'h00);
		send_item(CMD_QUERY, 3, 3, 8'h00);
		send_item(CMD_QUERY, 6, 5, 8'h00);
		send_item(CMD_QUERY, 2, 1, 8'h00);
		send_item(CMD_QUERY, 11, 7, 8'h00);
		send_item(CMD_QUERY, 12, 0, 8'h00);
		send_item(CMD_QUERY, 0, 8, 8'h00);
		settle();

		// zero register values act as one
		configure(0, 0, 0);
		send_item(CMD_QUERY, 0, 0, 8'h00);
		send_item(CMD_QUERY, 1, 0, 8'h00);
		send_item(CMD_LOAD, 0, 1, 8'h07);
		send_item(CMD_LOAD, 0, 0, 8'h01);
		send_item(CMD_QUERY, 0, 0, 8'h00);
		settle();

		// oversized values clamp to the maximum factor and size
		configure(31, 511, 300);
		send_item(CMD_QUERY, 0, 0, 8'h00);
		send_item(CMD_QUERY, 15, 15, 8'h00);
		send_item(CMD_QUERY, 4095, 4095, 8'h00);
		settle();

		foreach (plan[k]) begin
			configure(plan[k][0], plan[k][1], plan[k][2]);
			quiet = (k % 4 == 3);
			win_w = (eff_w < WINDOW) ? eff_w : WINDOW;
			win_h = (eff_h < WINDOW) ? eff_h : WINDOW;
			if (eff_w*eff_h <= WINDOW*WINDOW) begin
				win_w = eff_w;
				win_h = eff_h;
			end
			// whole image when small, else a top-left window plus the bottom-right corner
			for (y = 0; y < win_h; y++)
				for (x = 0; x < win_w; x++)
					send_item(CMD_LOAD, x, y, PIX_W'($urandom));
			x0 = (eff_w > 2) ? eff_w - 2 : 0;
			y0 = (eff_h > 2) ? eff_h - 2 : 0;
			for (y = y0; y < eff_h; y++)
				for (x = x0; x < eff_w; x++)
					send_item(CMD_LOAD, x, y, PIX_W'($urandom));

			repeat (PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					if ($urandom_range(0, 99) < 85) begin
						x = $urandom_range(0, eff_w - 1);
						y = $urandom_range(0, eff_h - 1);
					end else begin
						x = $urandom_range(0, 4095);
						y = $urandom_range(0, 4095);
					end
					case ($urandom_range(0, 9))
						0: send_item(CMD_LOAD, x, y, 8'h00);
						1: send_item(CMD_LOAD, x, y, 8'hff);
						default: send_item(CMD_LOAD, x, y, PIX_W'($urandom));
					endcase
				end else begin
					tries = 0;
					do begin
						if (pick < 53) begin
							x = $urandom_range(0, 4095);
							y = $urandom_range(0, 4095);
						end else if (pick < 75) begin
							x = $urandom_range(0, eff_w*eff_f - 1);
							y = $urandom_range(0, eff_h*eff_f - 1);
						end else if (pick < 90) begin
							x = $urandom_range(0, win_w*eff_f - 1);
							y = $urandom_range(0, win_h*eff_f - 1);
						end else begin
							x = $urandom_range(x0*eff_f, eff_w*eff_f - 1);
							y = $urandom_range(y0*eff_f, eff_h*eff_f - 1);
						end
						tries++;
					end while (!neighbors_loaded(x, y) && tries < 8);
					// first cell is always loaded
					if (!neighbors_loaded(x, y)) begin
						x = $urandom_range(0, eff_f - 1);
						y = $urandom_range(0, eff_f - 1);
					end
					send_item(CMD_QUERY, x, y, PIX_W'($urandom));
				end
			end
			settle();
		end

		$display("covered %0d loads (%0d dropped off the source image) and %0d queries",
			n_loads, n_dropped, n_queries);
		$display("%0d queries fell outside the enlarged image, across %0d register settings",
			n_flagged, n_settings);
		if (mismatches == 0 && waiting == 0)
			$display("bilinear_integer_upscale_unit_tb passed");
		else
			$display("bilinear_integer_upscale_unit_tb failed");
		$finish;
	end

endmodule
